/* hw/rtl/clsr_pkg.sv */
// Shared constants for the combined LCG / shuffle random number generator.
// Generator moduli, multipliers, fold constants and stream word widths.
// No dependencies.
package clsr_pkg;

	// Generator state width and multiplier width
	localparam int GEN_W  = 31;
	localparam int MUL_W  = 16;
	localparam int FOLD_W = 8;
	localparam int PROD_W = GEN_W + MUL_W;

	// Moduli are 2^31 minus a small fold constant
	localparam logic [GEN_W-1:0]  MOD_A  = 31'd2147483563;
	localparam logic [GEN_W-1:0]  MOD_B  = 31'd2147483399;
	localparam logic [FOLD_W-1:0] FOLD_A = 8'd85;
	localparam logic [FOLD_W-1:0] FOLD_B = 8'd249;
	localparam logic [MUL_W-1:0]  MUL_A  = 16'd40014;
	localparam logic [MUL_W-1:0]  MUL_B  = 16'd40692;

	// Reset values and output range
	localparam logic [GEN_W-1:0] GEN_A_INIT = 31'd1;
	localparam logic [GEN_W-1:0] GEN_B_INIT = 31'd123456789;
	localparam logic [GEN_W-1:0] TOP_SAMPLE = 31'd2147483562;

	// Warm-up steps beyond the table depth on a reseed
	localparam int WARMUP_EXTRA = 8;

	// Fraction output, Q0.24, held below one
	localparam int               FRAC_W   = 24;
	localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777214;

	// Stream word widths
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;

endpackage

/* hw/rtl/combined_lcg_shuffle_rng.sv */
// Combined two-modulus LCG with a Bays-Durham shuffle table held in RAM.
// Depends on clsr_pkg, clsr_gen_step and clsr_ram.
//
// Usage:
//   Input stream (s_axis): one word per request. tuser is the mode bit
//   (0 = draw, 1 = reseed from tdata then draw); tdata carries the seed.
//   Output stream (m_axis): one word per request with the sample and its
//   Q0.24 fraction.
//   A draw runs through the generator step (multiply, then fold), the
//   registered table read, the combine step and the slot computation for the
//   next draw in ST_SLOT0 and ST_SLOT1; a new request is accepted only once the
//   block is back in idle. A reseed runs 40 warm-up steps on the first
//   generator, each a multiply state and a fold state, writing the table,
//   then a normal draw. A draw that finds the first generator at zero
//   reseeds with 1 and takes as long as a reseed.
//   Reset puts the generators at 1 and 123456789 and the shuffle output at
//   zero; the table reads as zero through per-entry valid flags until an
//   entry is written, so no clearing pass is needed.
//   A stalled receiver holds the result in the output register; the next
//   request is still accepted, and its result waits for the register.
module combined_lcg_shuffle_rng import clsr_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// tdata: [30:0] seed_value, [31] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: [0] mode
	input  logic                   s_axis_tuser,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: [30:0] sample, [54:31] fraction, [55] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready
);

	localparam int SLOT_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + WARMUP_EXTRA);
	localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
	localparam int SCALE_W = GEN_W + DEPTH_W;
	localparam int PAD_W   = OUT_TDATA_W - GEN_W - FRAC_W;
	localparam logic [GEN_W-1:0] SLOT_DIV  = GEN_W'(1 + TOP_SAMPLE / TABLE_DEPTH);
	localparam logic [CNT_W-1:0] WARM_INIT = CNT_W'(TABLE_DEPTH + WARMUP_EXTRA - 1);

	// Sequencer states
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_WARM_MUL = 3'd1;
	localparam logic [2:0] ST_WARM_RED = 3'd2;
	localparam logic [2:0] ST_DRAW_MUL = 3'd3;
	localparam logic [2:0] ST_DRAW_RED = 3'd4;
	localparam logic [2:0] ST_COMBINE  = 3'd5;
	localparam logic [2:0] ST_SLOT0    = 3'd6;
	localparam logic [2:0] ST_SLOT1    = 3'd7;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   seeding_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [SLOT_W-1:0]      quot_q;
	logic [GEN_W-1:0]       gen_a_q;
	logic [GEN_W-1:0]       gen_b_q;
	logic [GEN_W-1:0]       shuffle_q;
	logic [GEN_W-1:0]       tab_s1;
	logic [FRAC_W-1:0]      frac_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   m_valid_q;
	logic [GEN_W-1:0]       m_sample_q;
	logic [FRAC_W-1:0]      m_frac_q;

	logic                   in_fire;
	logic                   out_free;
	logic                   out_load;
	logic                   reseed_go;
	logic [GEN_W-1:0]       seed_in;
	logic [GEN_W-1:0]       load_seed;
	logic [GEN_W-1:0]       next_a;
	logic [GEN_W-1:0]       next_b;
	logic                   ram_we;
	logic [SLOT_W-1:0]      ram_waddr;
	logic [GEN_W-1:0]       ram_rdata;
	logic [GEN_W+1:0]       diff;
	logic [GEN_W+1:0]       diff_wrap;
	logic [SCALE_W-1:0]     scale;
	logic [SLOT_W:0]        quot_inc;
	logic [GEN_W:0]         slot_bound;
	logic [SLOT_W:0]        slot_raw;
	logic [SLOT_W-1:0]      slot_next;
	logic [FRAC_W:0]        frac_inc;
	logic [GEN_W:0]         frac_test;
	logic [FRAC_W:0]        frac_raw;
	logic [FRAC_W-1:0]      frac_next;

	// Generator step unit
	clsr_gen_step u_gen (
		.clk    (clk),
		.gen_a  (gen_a_q),
		.gen_b  (gen_b_q),
		.next_a (next_a),
		.next_b (next_b)
	);

	// Shuffle table; the read address follows the current slot at all times
	clsr_ram #(
		.WIDTH (GEN_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (next_a),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// Handshake
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign out_load      = (state_q == ST_SLOT1) && !seeding_q && out_free;

	// Seed selection: zero seed becomes one, a zero generator forces seed one
	assign seed_in   = s_axis_tdata[GEN_W-1:0];
	assign reseed_go = s_axis_tuser || (gen_a_q == '0);
	assign load_seed = (s_axis_tuser && (seed_in != '0)) ? seed_in : GEN_W'(1);

	// Table write: warm-up fills from the top slot down, a draw refills its slot
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		unique case (state_q)
			ST_WARM_RED: begin
				ram_we    = (cnt_q < CNT_W'(TABLE_DEPTH));
				ram_waddr = cnt_q[SLOT_W-1:0];
			end
			ST_DRAW_RED: begin
				ram_we    = 1'b1;
			end
			default: begin
				ram_we    = 1'b0;
			end
		endcase
	end

	// Combine the table entry with the second generator, wrap into range
	assign diff      = {2'b00, tab_s1} - {2'b00, gen_b_q};
	assign diff_wrap = (diff[GEN_W+1] || (diff == '0)) ? diff + (GEN_W+2)'(TOP_SAMPLE) : diff;

	// Slot estimate: floor(x * depth / 2^31) is the quotient or one short
	assign scale      = SCALE_W'(shuffle_q) * SCALE_W'(TABLE_DEPTH);
	assign quot_inc   = (SLOT_W+1)'(quot_q) + (SLOT_W+1)'(1);
	assign slot_bound = (GEN_W+1)'(quot_inc) * (GEN_W+1)'(SLOT_DIV);
	assign slot_raw   = (slot_bound <= {1'b0, shuffle_q}) ? quot_inc : (SLOT_W+1)'(quot_q);
	assign slot_next  = (slot_raw >= (SLOT_W+1)'(TABLE_DEPTH)) ? SLOT_W'(TABLE_DEPTH - 1)
		: slot_raw[SLOT_W-1:0];

	// Fraction: x >> 7 is the quotient or one short, corrected by one test
	assign frac_inc  = (FRAC_W+1)'(shuffle_q[GEN_W-1:GEN_W-FRAC_W]) + (FRAC_W+1)'(1);
	assign frac_test = {1'b0, shuffle_q[GEN_W-FRAC_W-1:0], {FRAC_W{1'b0}}}
		+ ((GEN_W+1)'(frac_inc) * (GEN_W+1)'(FOLD_A));
	assign frac_raw  = (FRAC_W+1)'(shuffle_q[GEN_W-1:GEN_W-FRAC_W]) + (FRAC_W+1)'(frac_test[GEN_W]);
	assign frac_next = (frac_raw > (FRAC_W+1)'(FRAC_MAX)) ? FRAC_MAX : frac_raw[FRAC_W-1:0];

	// Sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			seeding_q  <= 1'b0;
			slot_q     <= '0;
			quot_q     <= '0;
			gen_a_q    <= GEN_A_INIT;
			gen_b_q    <= GEN_B_INIT;
			shuffle_q  <= '0;
			tab_s1     <= '0;
			frac_q     <= '0;
			valid_q    <= '0;
			m_valid_q  <= 1'b0;
			m_sample_q <= '0;
			m_frac_q   <= '0;
		end else begin
			// Output valid: set on a new result, cleared when the word is taken
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (reseed_go) begin
							gen_a_q   <= load_seed;
							gen_b_q   <= load_seed;
							cnt_q     <= WARM_INIT;
							seeding_q <= 1'b1;
							state_q   <= ST_WARM_MUL;
						end else begin
							seeding_q <= 1'b0;
							state_q   <= ST_DRAW_RED;
						end
					end
				end
				ST_WARM_MUL: begin
					state_q <= ST_WARM_RED;
				end
				ST_WARM_RED: begin
					gen_a_q <= next_a;
					if (cnt_q == '0) begin
						shuffle_q <= next_a;
						state_q   <= ST_SLOT0;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= ST_WARM_MUL;
					end
				end
				ST_DRAW_MUL: begin
					seeding_q <= 1'b0;
					state_q   <= ST_DRAW_RED;
				end
				ST_DRAW_RED: begin
					gen_a_q <= next_a;
					gen_b_q <= next_b;
					tab_s1  <= valid_q[slot_q] ? ram_rdata : '0;
					state_q <= ST_COMBINE;
				end
				ST_COMBINE: begin
					shuffle_q <= diff_wrap[GEN_W-1:0];
					state_q   <= ST_SLOT0;
				end
				ST_SLOT0: begin
					quot_q  <= scale[GEN_W +: SLOT_W];
					frac_q  <= frac_next;
					state_q <= ST_SLOT1;
				end
				ST_SLOT1: begin
					slot_q <= slot_next;
					if (seeding_q) begin
						state_q <= ST_DRAW_MUL;
					end else if (out_free) begin
						m_sample_q <= shuffle_q;
						m_frac_q   <= frac_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output word
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, m_frac_q, m_sample_q};

endmodule

/* hw/rtl/clsr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the shuffle table. No dependencies.
module clsr_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/clsr_gen_step.sv */
// Step of both congruential generators: x * mul mod m.
// Product is registered, then folded using 2^31 = fold (mod m).
// Depends on clsr_pkg.
module clsr_gen_step import clsr_pkg::*; (
	input  logic             clk,
	input  logic [GEN_W-1:0] gen_a,
	input  logic [GEN_W-1:0] gen_b,
	output logic [GEN_W-1:0] next_a,
	output logic [GEN_W-1:0] next_b
);

	logic [PROD_W-1:0] prod_a_s1;
	logic [PROD_W-1:0] prod_b_s1;

	// Fold high part back in, one conditional subtract finishes the reduction
	function automatic logic [GEN_W-1:0] fold_mod(
		input logic [PROD_W-1:0] p,
		input logic [FOLD_W-1:0] c,
		input logic [GEN_W-1:0]  m
	);
		logic [GEN_W:0] t;
		t = {1'b0, p[GEN_W-1:0]}
			+ ((GEN_W+1)'(p[PROD_W-1:GEN_W]) * (GEN_W+1)'(c));
		if (t >= {1'b0, m}) begin
			t = t - {1'b0, m};
		end
		return t[GEN_W-1:0];
	endfunction

	// Multiplier stage
	always_ff @(posedge clk) begin
		prod_a_s1 <= PROD_W'(gen_a) * PROD_W'(MUL_A);
		prod_b_s1 <= PROD_W'(gen_b) * PROD_W'(MUL_B);
	end

	assign next_a = fold_mod(prod_a_s1, FOLD_A, MOD_A);
	assign next_b = fold_mod(prod_b_s1, FOLD_B, MOD_B);

endmodule

/* hw/rtl/clsr_checker.sv */
// Port-level checks for the combined LCG / shuffle generator, bound to the top.
// Depends on clsr_pkg and combined_lcg_shuffle_rng.
module clsr_checker import clsr_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                   s_axis_tuser,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready
);

	logic [GEN_W-1:0]  sample;
	logic [FRAC_W-1:0] fraction;
	logic [FRAC_W:0]   frac_base;

	assign sample    = m_axis_tdata[GEN_W-1:0];
	assign fraction  = m_axis_tdata[GEN_W+FRAC_W-1:GEN_W];
	assign frac_base = (FRAC_W+1)'(sample[GEN_W-1:GEN_W-FRAC_W]);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed or dropped while stalled");

	// Sample lies in 1..TOP_SAMPLE and padding is zero
	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (sample != '0) && (sample <= TOP_SAMPLE)
			&& (m_axis_tdata[OUT_TDATA_W-1] == 1'b0))
		else $error("sample out of range");

	// Fraction agrees with the sample it goes with
	a_frac_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((FRAC_W+1)'(fraction) == frac_base)
			|| ((FRAC_W+1)'(fraction) == frac_base + (FRAC_W+1)'(1))
			|| (fraction == FRAC_MAX))
		else $error("fraction does not match sample");

	// No two requests are accepted on consecutive cycles
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted on consecutive cycles");

	// No result appears the cycle after a request is taken while no result is waiting
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result produced too early");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (.*);

/* tb/clsr_draw_monitor.sv */
// Draw monitor for the combined LCG / shuffle generator: predicts each result word
// from the accepted request words and compares it with the output stream.
// Depends on clsr_pkg.
`timescale 1ns / 1ps

module clsr_draw_monitor import clsr_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// tdata: [30:0] seed_value, [31] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: [0] mode
	input  logic                   s_axis_tuser,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// tdata: [30:0] sample, [54:31] fraction, [55] zero
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output int                     fail_count,
	output int                     pending
);

	// Schrage split constants (quotient and remainder of modulus by multiplier)
	localparam longint QUO_A    = 53668;
	localparam longint QUO_B    = 52774;
	localparam longint REM_A    = 12211;
	localparam longint REM_B    = 3791;
	localparam longint SLOT_DIV = 1 + longint'(TOP_SAMPLE) / TABLE_DEPTH;

	typedef struct packed {
		logic [GEN_W-1:0]  sample;
		logic [FRAC_W-1:0] fraction;
	} draw_t;

	// Predicted generator state
	longint gen_a;
	longint gen_b;
	longint shuffled;
	longint slots [TABLE_DEPTH];
	draw_t  expected_draws [$];

	// mul * x mod m without overflow
	function automatic longint schrage_step(longint x, longint mul, longint quo,
			longint rem, longint m);
		longint k;
		longint v;
		k = x / quo;
		v = mul * (x - k * quo) - k * rem;
		if (v < 0)
			v += m;
		return v;
	endfunction

	// Load both generators and refill the table from the warm-up run
	function automatic void load_seed(longint seed);
		if (seed < 1)
			seed = 1;
		gen_a = seed;
		gen_b = seed;
		for (int j = TABLE_DEPTH + WARMUP_EXTRA - 1; j >= 0; j--) begin
			gen_a = schrage_step(gen_a, longint'(MUL_A), QUO_A, REM_A, longint'(MOD_A));
			if (j < TABLE_DEPTH)
				slots[j] = gen_a;
		end
		shuffled = slots[0];
	endfunction

	// One request: optional reseed, generator steps, table swap, scaling
	function automatic draw_t predict_draw(logic reseed, longint seed);
		longint      slot;
		logic [63:0] scaled;
		draw_t       d;
		if (reseed)
			load_seed(seed);
		else if (gen_a <= 0)
			load_seed(1);
		gen_a = schrage_step(gen_a, longint'(MUL_A), QUO_A, REM_A, longint'(MOD_A));
		gen_b = schrage_step(gen_b, longint'(MUL_B), QUO_B, REM_B, longint'(MOD_B));
		slot = shuffled / SLOT_DIV;
		if (slot < 0 || slot >= TABLE_DEPTH)
			slot = TABLE_DEPTH - 1;
		shuffled = slots[slot] - gen_b;
		slots[slot] = gen_a;
		if (shuffled < 1)
			shuffled += longint'(TOP_SAMPLE);
		scaled = shuffled;
		scaled = (scaled << FRAC_W) / MOD_A;
		if (scaled > FRAC_MAX)
			scaled = FRAC_MAX;
		d.sample   = shuffled[GEN_W-1:0];
		d.fraction = scaled[FRAC_W-1:0];
		return d;
	endfunction

	// Watch both channels; results are matched before new requests are queued
	always @(posedge clk or negedge arst_n) begin
		draw_t got;
		draw_t want;
		if (!arst_n) begin
			gen_a      = longint'(GEN_A_INIT);
			gen_b      = longint'(GEN_B_INIT);
			shuffled   = 0;
			foreach (slots[i])
				slots[i] = 0;
			expected_draws.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.sample   = m_axis_tdata[GEN_W-1:0];
				got.fraction = m_axis_tdata[GEN_W +: FRAC_W];
				if (expected_draws.size() == 0) begin
					$error("result word with no request outstanding: sample %0d", got.sample);
					fail_count++;
				end else begin
					want = expected_draws.pop_front();
					if (got.sample !== want.sample) begin
						$error("sample: expected %0d, actual %0d", want.sample, got.sample);
						fail_count++;
					end
					if (got.fraction !== want.fraction) begin
						$error("fraction: expected %0d, actual %0d",
							want.fraction, got.fraction);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_draws.push_back(predict_draw(s_axis_tuser,
					longint'(s_axis_tdata[GEN_W-1:0])));
			pending = expected_draws.size();
		end
	end

endmodule

/* tb/combined_lcg_shuffle_rng_tb.sv */
// Top of the testbench for combined_lcg_shuffle_rng: clock, reset, request stimulus,
// receiver back-pressure, watchdog and verdict. Checking sits in clsr_draw_monitor.
// Depends on clsr_pkg, combined_lcg_shuffle_rng and clsr_draw_monitor.
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_tb;
	import clsr_pkg::*;

	localparam int   TABLE_DEPTH     = 32;
	localparam logic MODE_DRAW       = 1'b0;
	localparam logic MODE_RESEED     = 1'b1;
	localparam int   RANDOM_REQUESTS = 400;
	// covers a reseed plus the receiver's longest stall
	localparam int   WATCHDOG_LIMIT  = 2000;
	localparam int   DRAIN_CYCLES    = 20;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   s_axis_tuser  = MODE_DRAW;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;

	int        fail_count;
	int        outstanding;
	int        burst_left  = 0;
	int        idle_cycles = 0;
	rx_style_t rx_style    = RX_OPEN;
	int        rx_left     = 0;
	int        rx_period   = 4;
	int        rx_tick     = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	combined_lcg_shuffle_rng #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready)
	);

	clsr_draw_monitor #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_draw_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.fail_count   (fail_count),
		.pending      (outstanding)
	);

	// Send one request word; bursts of random length with random gaps between
	task automatic send_request(input logic mode, input logic [GEN_W-1:0] seed);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 64)
				: $urandom_range(1, 16);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {1'b0, seed};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
	endtask

	// Receiver back-pressure: a style held for a random stretch, then another
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style  = rx_style_t'($urandom_range(0, 3));
			rx_left   = $urandom_range(32, 256);
			rx_period = $urandom_range(2, 16);
		end else
			rx_left--;
		rx_tick++;
		case (rx_style)
			RX_OPEN:  m_axis_tready <= 1'b1;
			RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default:  m_axis_tready <= (rx_tick % rx_period == 0);
		endcase
	end

	// Watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [GEN_W-1:0] seed;
		int               kind;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// draws straight from the reset state, seed field ignored
		send_request(MODE_DRAW, '0);
		send_request(MODE_DRAW, '1);
		send_request(MODE_DRAW, 31'h2AAA_AAAA);
		// seed of zero maps to one, then one itself
		send_request(MODE_RESEED, '0);
		send_request(MODE_DRAW, 31'h5555_5555);
		send_request(MODE_RESEED, 31'd1);
		send_request(MODE_DRAW, '0);
		// largest seed, above both moduli
		send_request(MODE_RESEED, '1);
		send_request(MODE_DRAW, '0);
		// first modulus: first generator collapses, next draw reseeds with one
		send_request(MODE_RESEED, MOD_A);
		send_request(MODE_DRAW, '0);
		send_request(MODE_DRAW, '0);
		// second modulus: second generator stuck at zero
		send_request(MODE_RESEED, MOD_B);
		send_request(MODE_DRAW, '0);
		send_request(MODE_DRAW, '1);
		// seeds around the moduli and alternating bit patterns
		send_request(MODE_RESEED, MOD_A - 31'd1);
		send_request(MODE_RESEED, MOD_A + 31'd1);
		send_request(MODE_RESEED, MOD_B - 31'd1);
		send_request(MODE_RESEED, 31'h5555_5555);
		send_request(MODE_DRAW, '0);
		send_request(MODE_RESEED, 31'h2AAA_AAAA);
		send_request(MODE_DRAW, '0);

		// random part: mostly draws, the odd reseed
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			seed = GEN_W'($urandom());
			if ($urandom_range(0, 11) == 0) begin
				kind = $urandom_range(0, 9);
				case (kind)
					0:       seed = '0;
					1:       seed = MOD_A;
					2:       seed = MOD_B;
					3:       seed = '1;
					4:       seed = GEN_W'($urandom_range(1, 1000));
					default: ;
				endcase
				send_request(MODE_RESEED, seed);
			end else
				send_request(MODE_DRAW, seed);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
